// ----- src/sis_pkg.sv -----
// Package for the sorted integer set: sizes, function and status codes,
// controller states and the cell control struct.
// No dependencies.
`timescale 1ns / 1ps

package sis_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 64;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  typedef enum logic [1:0] {
    FN_ADD      = 2'd0,
    FN_REMOVE   = 2'd1,
    FN_CONTAINS = 2'd2,
    FN_READ     = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_MISS   = 3'd1,
    ST_FULL   = 3'd2,
    ST_LOCKED = 3'd3,
    ST_RANGE  = 3'd4
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_UPD  = 1'b1
  } state_e;

  typedef struct packed {
    logic ins;
    logic del;
  } cell_ctrl_t;

endpackage

// ----- src/sorted_integer_set_core.sv -----
// Top level of the sorted integer set: controller, result register and the
// chain of storage cells. Depends on sis_pkg and sis_cell.
// The cell chain registers the compare on the input transfer; the update
// state then writes the cells and the result register.
// A new request is not taken during the update pass through the cell chain
// or while a held result is stalled; this does not depend on fill.
// Reset: clears the entry count, the lock bit and all handshake state; entry
// contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps

module sorted_integer_set_core import sis_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic                     cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               func_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic [IDX_W-1:0]         position_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [2:0]               status_o,
  output logic signed [DATA_W-1:0] read_value_o,
  output logic [CNT_W-1:0]         entry_count_o
);

  state_e state_q, state_d;
  logic   in_xfer, upd_en;

  logic                     locked_q;
  logic [CNT_W-1:0]         count_q, count_d;
  func_e                    func_q;
  logic signed [DATA_W-1:0] value_q;
  logic                     in_range_q;

  logic                     out_valid_q, out_valid_d;
  status_e                  status_q, status_d;
  logic signed [DATA_W-1:0] read_value_q, read_value_d;

  cell_ctrl_t               ctrl;
  logic signed [DATA_W-1:0] entry_w [CAPACITY];
  logic signed [DATA_W-1:0] rd_w    [CAPACITY];
  logic [CAPACITY-1:0]      lt_w, eq_w;
  logic signed [DATA_W-1:0] rd_all;
  logic                     found, full;

  // Controller
  always_comb begin
    unique case (state_q)
      S_IDLE:  state_d = in_xfer ? S_UPD : S_IDLE;
      S_UPD:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = out_valid_q && out_stall_i;
        upd_en     = 1'b0;
      end
      S_UPD: begin
        in_stall_o = 1'b1;
        upd_en     = 1'b1;
      end
      default: begin
        in_stall_o = 1'b1;
        upd_en     = 1'b0;
      end
    endcase
  end

  assign in_xfer     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Cell chain
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [DATA_W-1:0] prev_entry, next_entry;
    logic                     prev_lt;
    if (g == 0) begin : g_first
      assign prev_entry = '0;
      assign prev_lt    = 1'b1;
    end else begin : g_mid
      assign prev_entry = entry_w[g-1];
      assign prev_lt    = lt_w[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign next_entry = '0;
    end else begin : g_notlast
      assign next_entry = entry_w[g+1];
    end

    sis_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .idx_i        (IDX_W'(g)),
      .cnt_i        (count_q),
      .cmp_en_i     (in_xfer),
      .value_i      (value_i),
      .position_i   (position_i),
      .ctrl_i       (ctrl),
      .new_value_i  (value_q),
      .prev_entry_i (prev_entry),
      .next_entry_i (next_entry),
      .prev_lt_i    (prev_lt),
      .entry_o      (entry_w[g]),
      .lt_o         (lt_w[g]),
      .eq_o         (eq_w[g]),
      .rd_o         (rd_w[g])
    );
  end

  always_comb begin
    rd_all = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_all = rd_all | rd_w[i];
    end
  end

  assign found = |eq_w;
  assign full  = count_q == CAP_CNT;

  // Update decision
  always_comb begin
    ctrl         = '0;
    count_d      = count_q;
    status_d     = status_q;
    read_value_d = read_value_q;
    out_valid_d  = out_valid_q && out_stall_i;
    if (upd_en) begin
      out_valid_d  = 1'b1;
      status_d     = ST_OK;
      read_value_d = '0;
      unique case (func_q)
        FN_ADD: begin
          priority if (locked_q) begin
            status_d = ST_LOCKED;
          end else if (found) begin
            status_d = ST_MISS;
          end else if (full) begin
            status_d = ST_FULL;
          end else begin
            ctrl.ins = 1'b1;
            count_d  = count_q + 1'b1;
          end
        end
        FN_REMOVE: begin
          priority if (locked_q) begin
            status_d = ST_LOCKED;
          end else if (!found) begin
            status_d = ST_MISS;
          end else begin
            ctrl.del = 1'b1;
            count_d  = count_q - 1'b1;
          end
        end
        FN_CONTAINS: begin
          status_d = found ? ST_OK : ST_MISS;
        end
        FN_READ: begin
          if (in_range_q) begin
            read_value_d = rd_all;
          end else begin
            status_d = ST_RANGE;
          end
        end
        default: status_d = ST_OK;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      locked_q    <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      status_q    <= ST_OK;
      func_q      <= FN_ADD;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
      if (cfg_valid_i && cfg_ready_o) begin
        locked_q <= cfg_data_i;
      end
      if (in_xfer) begin
        func_q <= func_e'(func_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    read_value_q <= read_value_d;
    if (in_xfer) begin
      value_q    <= value_i;
      in_range_q <= {1'b0, position_i} < count_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign read_value_o  = read_value_q;
  assign entry_count_o = count_q;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP_CNT)
    else $error("entry count above capacity");

  a_xfer_to_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q == S_UPD)
    else $error("transfer not followed by update");

  a_result_from_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_UPD))
    else $error("result without update");

  a_count_only_on_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_UPD |=> $stable(count_q))
    else $error("entry count changed outside update");

endmodule

// ----- src/sis_cell.sv -----
// One storage cell of the sorted set chain: holds one entry, compares it
// against the request value and shifts to or from its neighbors.
// Depends on sis_pkg.
`timescale 1ns / 1ps

module sis_cell import sis_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [IDX_W-1:0]         idx_i,
  input  logic [CNT_W-1:0]         cnt_i,
  input  logic                     cmp_en_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic [IDX_W-1:0]         position_i,
  input  cell_ctrl_t               ctrl_i,
  input  logic signed [DATA_W-1:0] new_value_i,
  input  logic signed [DATA_W-1:0] prev_entry_i,
  input  logic signed [DATA_W-1:0] next_entry_i,
  input  logic                     prev_lt_i,
  output logic signed [DATA_W-1:0] entry_o,
  output logic                     lt_o,
  output logic                     eq_o,
  output logic signed [DATA_W-1:0] rd_o
);

  logic signed [DATA_W-1:0] entry_q, entry_d;
  logic lt_q, lt_d, eq_q, eq_d, hit_q, hit_d;
  logic occupied;

  assign occupied = {1'b0, idx_i} < cnt_i;

  always_comb begin
    lt_d  = lt_q;
    eq_d  = eq_q;
    hit_d = hit_q;
    if (cmp_en_i) begin
      lt_d  = occupied && (entry_q < value_i);
      eq_d  = occupied && (entry_q == value_i);
      hit_d = occupied && (position_i == idx_i);
    end
  end

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins && !lt_q) begin
      entry_d = prev_lt_i ? new_value_i : prev_entry_i;
    end else if (ctrl_i.del && !lt_q) begin
      entry_d = next_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q  <= 1'b0;
      eq_q  <= 1'b0;
      hit_q <= 1'b0;
    end else begin
      lt_q  <= lt_d;
      eq_q  <= eq_d;
      hit_q <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign lt_o    = lt_q;
  assign eq_o    = eq_q;
  assign rd_o    = hit_q ? entry_q : '0;

endmodule
